// ===== design/filmic_tone_map_xyz_to_srgb_defines.svh =====
// assertion macros for the filmic tone mapper
// no dependencies; included by the top level only
`ifndef FILMIC_TONE_MAP_XYZ_TO_SRGB_DEFINES_SVH
`define FILMIC_TONE_MAP_XYZ_TO_SRGB_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FTM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define FTM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ftm_pkg.sv =====
// types, constants and shared arithmetic for the filmic tone mapper
// no dependencies; used by ftm_curve, the top level and the bench
package ftm_pkg;

  localparam int NUM_CH     = 3;
  localparam int IN_W       = 32;
  localparam int GAIN_W     = 24;
  localparam int WHITE_W    = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int T_W        = 29;
  localparam int T2_W       = 57;
  localparam int TERM_W     = 62;
  localparam int DEN_W      = 43;
  localparam int SH_W       = 5;
  localparam int F_W        = 20;
  localparam int WCR_W      = 32;
  localparam int NORM_W     = 32;
  localparam int LIN_W      = 33;
  localparam int COEF_W     = 24;
  localparam int PROD_W     = 58;
  localparam int ACC_W      = 60;
  localparam int V_W        = 21;
  localparam int CODE_W     = 8;
  localparam int DIV_STEPS  = 20;
  localparam int RDIV_STEPS = 41;
  localparam int CNT_W      = 6;
  localparam int CURVE_LAT  = 5 + DIV_STEPS;

  localparam logic [GAIN_W-1:0]  GAIN_RST  = 24'd65536;
  localparam logic [WHITE_W-1:0] WHITE_RST = 32'd65536;
  localparam logic [T_W-1:0]     T_CAP     = 29'd268435456;
  localparam logic [V_W-1:0]     Q20_ONE   = 21'd1048576;
  localparam logic [ACC_W-1:0]   HALF20    = 60'd524288;

  // d65 white point scale for x and z, q20 rounded
  localparam logic [20:0] D65_XF = 21'((64'd31271 * 64'd1048576 + 64'd16451) / 64'd32902);
  localparam logic [20:0] D65_ZF = 21'((64'd35827 * 64'd1048576 + 64'd16451) / 64'd32902);

  typedef logic signed [COEF_W-1:0] coef_t;

  localparam longint QS = 1048576;
  localparam longint QR = 5000000;
  localparam longint QD = 10000000;

  // xyz to linear srgb, q20 rounded
  localparam coef_t RGB_M [NUM_CH][NUM_CH] = '{
    '{ coef_t'((64'sd32404542 * QS + QR) / QD),
      -coef_t'((64'sd15371385 * QS + QR) / QD),
      -coef_t'((64'sd4985314 * QS + QR) / QD) },
    '{-coef_t'((64'sd9692660 * QS + QR) / QD),
       coef_t'((64'sd18760108 * QS + QR) / QD),
       coef_t'((64'sd415560 * QS + QR) / QD) },
    '{ coef_t'((64'sd556434 * QS + QR) / QD),
      -coef_t'((64'sd2040259 * QS + QR) / QD),
       coef_t'((64'sd10572252 * QS + QR) / QD) }
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXPOSURE_GAIN = 1'b0,
    REG_WHITE_LEVEL   = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    WS_IDLE,
    WS_SCALE,
    WS_SQUARE,
    WS_TERMS,
    WS_NORM,
    WS_FDIV,
    WS_RDIV
  } wsq_e;

  typedef struct packed {
    logic [IN_W-1:0] cie_x;
    logic [IN_W-1:0] cie_y;
    logic [IN_W-1:0] cie_z;
  } pix_in_t;

  typedef struct packed {
    logic [CODE_W-1:0] red;
    logic [CODE_W-1:0] green;
    logic [CODE_W-1:0] blue;
  } rgb_out_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [F_W-1:0]   quo;
  } dstep_t;

  typedef logic [255:0][V_W-1:0] gamma_tbl_t;

  // exposure scale, q16, capped at 4096.0
  function automatic logic [T_W-1:0] scale_exp_f(logic [IN_W-1:0] v, logic [GAIN_W-1:0] g);
    logic [55:0] p;
    p = 56'(v) * 56'(g);
    if (p[55:16] > 40'(T_CAP)) begin
      return T_CAP;
    end
    return p[44:16];
  endfunction

  function automatic logic [TERM_W-1:0] curve_num_f(logic [T_W-1:0] t, logic [T2_W-1:0] t2);
    return 62'(t2) * 62'd42 + 62'(t) * 62'd327680;
  endfunction

  function automatic logic [TERM_W-1:0] curve_den_f(logic [T_W-1:0] t, logic [T2_W-1:0] t2);
    return 62'(t2) * 62'd45 + 62'(t) * 62'd9830400 + (62'd18 << 32);
  endfunction

  // right shift that brings the denominator below 2^43
  function automatic logic [SH_W-1:0] norm_shift_f(logic [TERM_W-1:0] den);
    logic [SH_W-1:0] sh;
    sh = '0;
    for (int i = 0; i < TERM_W - DEN_W; i++) begin
      if (den[DEN_W + i]) begin
        sh = SH_W'(i + 1);
      end
    end
    return sh;
  endfunction

  // one restoring division step, one quotient bit
  function automatic dstep_t div_step_f(logic [DEN_W-1:0] rem, logic [DEN_W-1:0] den,
                                        logic [F_W-1:0] quo);
    dstep_t     o;
    logic [DEN_W:0] r2;
    r2 = {rem, 1'b0};
    if (r2 >= {1'b0, den}) begin
      o.rem = DEN_W'(r2 - {1'b0, den});
      o.quo = {quo[F_W-2:0], 1'b1};
    end else begin
      o.rem = r2[DEN_W-1:0];
      o.quo = {quo[F_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // gamma decision thresholds in q20, entry k splits codes k-1 and k
  function automatic gamma_tbl_t gamma_tbl_f();
    gamma_tbl_t      tbl;
    longint unsigned m, uq, u2, lo, hi, mid, a, b, p;
    tbl = '0;
    for (int k = 1; k < 256; k++) begin
      m = 64'(2 * k - 1);
      if (k <= 10) begin
        tbl[k] = V_W'((m * 64'd100 * 64'd1048576 + 64'd658919) / 64'd658920);
      end else begin
        uq = ((m * 64'd1000 + 64'd28050) << 30) / 64'd538050;
        u2 = (uq * uq) >> 40;
        lo = 64'd0;
        hi = 64'd1 << 20;
        for (int it = 0; it < 24; it++) begin
          if (lo < hi) begin
            mid = (lo + hi + 64'd1) / 64'd2;
            a = (mid * mid) >> 20;
            b = (a * a) >> 20;
            p = (b * mid) >> 20;
            if (p <= u2) begin
              lo = mid;
            end else begin
              hi = mid - 64'd1;
            end
          end
        end
        tbl[k] = V_W'((u2 * lo) >> 20);
      end
    end
    return tbl;
  endfunction

  localparam gamma_tbl_t GAMMA_THR = gamma_tbl_f();

endpackage

// ===== design/ftm_curve.sv =====
// three-lane pipeline: exposure scale, filmic curve terms and the curve division
// depends on ftm_pkg
module ftm_curve import ftm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  pix_in_t           pix_i,
  input  logic [GAIN_W-1:0] gain_i,
  output logic              valid_o,
  output logic [F_W-1:0]    f_o [NUM_CH]
);

  logic [CURVE_LAT-1:0] vld_q;
  logic [IN_W-1:0]      lane [NUM_CH];

  logic [T_W-1:0]    s1_t_q   [NUM_CH];
  logic [T_W-1:0]    s2_t_q   [NUM_CH];
  logic [T2_W-1:0]   s2_t2_q  [NUM_CH];
  logic [TERM_W-1:0] s3_num_q [NUM_CH];
  logic [TERM_W-1:0] s3_den_q [NUM_CH];
  logic [TERM_W-1:0] s4_num_q [NUM_CH];
  logic [TERM_W-1:0] s4_den_q [NUM_CH];
  logic [SH_W-1:0]   s4_sh_q  [NUM_CH];

  logic [DEN_W-1:0] dv_rem_q [DIV_STEPS][NUM_CH];
  logic [DEN_W-1:0] dv_den_q [DIV_STEPS][NUM_CH];
  logic [F_W-1:0]   dv_quo_q [1:DIV_STEPS-1][NUM_CH];
  logic [F_W-1:0]   f_q      [NUM_CH];
  dstep_t           dv_d     [DIV_STEPS][NUM_CH];

  assign lane[0] = pix_i.cie_x;
  assign lane[1] = pix_i.cie_y;
  assign lane[2] = pix_i.cie_z;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      dv_d[0][c] = div_step_f(dv_rem_q[0][c], dv_den_q[0][c], '0);
      for (int j = 1; j < DIV_STEPS; j++) begin
        dv_d[j][c] = div_step_f(dv_rem_q[j][c], dv_den_q[j][c], dv_quo_q[j][c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[CURVE_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NUM_CH; c++) begin
      s1_t_q[c]   <= scale_exp_f(lane[c], gain_i);
      s2_t_q[c]   <= s1_t_q[c];
      s2_t2_q[c]  <= T2_W'(s1_t_q[c]) * T2_W'(s1_t_q[c]);
      s3_num_q[c] <= curve_num_f(s2_t_q[c], s2_t2_q[c]);
      s3_den_q[c] <= curve_den_f(s2_t_q[c], s2_t2_q[c]);
      s4_num_q[c] <= s3_num_q[c];
      s4_den_q[c] <= s3_den_q[c];
      s4_sh_q[c]  <= norm_shift_f(s3_den_q[c]);
      dv_rem_q[0][c] <= DEN_W'(s4_num_q[c] >> s4_sh_q[c]);
      dv_den_q[0][c] <= DEN_W'(s4_den_q[c] >> s4_sh_q[c]);
      for (int j = 1; j < DIV_STEPS; j++) begin
        dv_rem_q[j][c] <= dv_d[j-1][c].rem;
        dv_den_q[j][c] <= dv_den_q[j-1][c];
        dv_quo_q[j][c] <= dv_d[j-1][c].quo;
      end
      f_q[c] <= dv_d[DIV_STEPS-1][c].quo;
    end
  end

  assign valid_o = vld_q[CURVE_LAT-1];
  assign f_o     = f_q;

endmodule

// ===== design/filmic_tone_map_xyz_to_srgb.sv =====
// filmic tone mapper top level: cie xyz q16.16 in, 8-bit gamma-encoded srgb out
// depends on ftm_pkg, ftm_curve and filmic_tone_map_xyz_to_srgb_defines.svh
//
// usage
//   input beat: pix_i is taken at a rising edge with start high and busy low
//   result beat: res_o is valid for exactly one cycle, marked by res_valid_o
//   config: cfg_we_i writes cfg_data_i to register cfg_idx_i
//     (0 exposure gain q8.16, 1 white level q16.16), no wait states
//   throughput: one pixel per clock while busy is low
//   pipeline: an accepted pixel passes 25 stages exposure/curve (incl. a
//     20-stage divider), normalize, d65 scale, matrix products, row sum/clamp
//     and an 8-stage gamma search before its result beat
//   busy: high after reset and after each config write while
//     a sequential unit finds the reciprocal of the curve at white
//     (4 setup steps, 20 curve division steps, 41 reciprocal steps)
//   reset: registers return to 1.0, pipeline valid bits clear, recompute starts
//   the receiver cannot stall: every result beat is taken as it comes
`include "filmic_tone_map_xyz_to_srgb_defines.svh"

module filmic_tone_map_xyz_to_srgb import ftm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  pix_in_t               pix_i,
  output logic                  res_valid_o,
  output rgb_out_t              res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // edges from the accepting edge to the edge that takes the result beat
  localparam int PIPE_LAT = CURVE_LAT + 4 + CODE_W;

  // configuration registers
  logic [GAIN_W-1:0]  gain_q;
  logic [WHITE_W-1:0] white_q;

  // white reciprocal sequencer
  wsq_e              state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [T_W-1:0]    wt_q;
  logic [T2_W-1:0]   wt2_q;
  logic [TERM_W-1:0] wnum_q, wden_q;
  logic [DEN_W-1:0]  wrem_q, wdn_q;
  logic [F_W-1:0]    wquo_q;
  logic [F_W-1:0]    rrem_q;
  logic [RDIV_STEPS-1:0] rquo_q;
  logic [WCR_W-1:0]  wcr_q;
  logic [SH_W-1:0]   wsh;
  dstep_t            wstep;
  logic              rbit;
  logic [F_W:0]      rr2;
  logic [F_W-1:0]    rrem_n;
  logic [RDIV_STEPS-1:0] rquo_n;
  logic [WCR_W-1:0]  wcr_n;

  // pixel pipeline
  logic              acc;
  logic              cv_vld;
  logic [F_W-1:0]    cv_f [NUM_CH];
  logic              n_vld_q, l_vld_q, m_vld_q;
  logic [NORM_W-1:0] n_q [NUM_CH];
  logic [LIN_W-1:0]  lin_q [NUM_CH];
  logic signed [PROD_W-1:0] mp_q [NUM_CH][NUM_CH];
  logic [CODE_W:0]   g_vld_q;
  logic [V_W-1:0]    gv_q [CODE_W+1][NUM_CH];
  logic [CODE_W-1:0] gc_q [CODE_W+1][NUM_CH];

  logic [51:0]       nprod [NUM_CH];
  logic [52:0]       lprod [NUM_CH];
  logic signed [ACC_W-1:0] rsum [NUM_CH];
  logic [ACC_W-1:0]  rrnd [NUM_CH];
  logic [V_W-1:0]    vlin [NUM_CH];
  logic [CODE_W-1:0] gcand [1:CODE_W][NUM_CH];

  //--------------------------------------------------------------------------
  // configuration port
  //--------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= GAIN_RST;
      white_q <= WHITE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_EXPOSURE_GAIN: gain_q  <= cfg_data_i[GAIN_W-1:0];
        REG_WHITE_LEVEL:   white_q <= cfg_data_i[WHITE_W-1:0];
        default: ;
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // white reciprocal: curve at white*gain, then 2^40 / f, saturated
  //--------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= WS_SCALE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    busy    = (state_q != WS_IDLE);
    unique case (state_q)
      WS_IDLE:   ;
      WS_SCALE:  state_d = WS_SQUARE;
      WS_SQUARE: state_d = WS_TERMS;
      WS_TERMS:  state_d = WS_NORM;
      WS_NORM: begin
        state_d = WS_FDIV;
        cnt_d   = CNT_W'(DIV_STEPS - 1);
      end
      WS_FDIV: begin
        if (cnt_q == '0) begin
          state_d = WS_RDIV;
          cnt_d   = CNT_W'(RDIV_STEPS - 1);
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      WS_RDIV: begin
        if (cnt_q == '0) begin
          state_d = WS_IDLE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: state_d = WS_IDLE;
    endcase
    // a register write restarts the recompute with the new value
    if (cfg_we_i) begin
      state_d = WS_SCALE;
    end
  end

  assign wsh   = norm_shift_f(wden_q);
  assign wstep = div_step_f(wrem_q, wdn_q, wquo_q);

  // dividend 2^40: its only set bit enters on the first step
  always_comb begin
    rbit = (cnt_q == CNT_W'(RDIV_STEPS - 1));
    rr2  = {rrem_q, rbit};
    if (rr2 >= {1'b0, wquo_q}) begin
      rrem_n = F_W'(rr2 - {1'b0, wquo_q});
      rquo_n = {rquo_q[RDIV_STEPS-2:0], 1'b1};
    end else begin
      rrem_n = rr2[F_W-1:0];
      rquo_n = {rquo_q[RDIV_STEPS-2:0], 1'b0};
    end
    if (wquo_q == '0 || rquo_n[RDIV_STEPS-1:WCR_W] != '0) begin
      wcr_n = '1;
    end else begin
      wcr_n = rquo_n[WCR_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      WS_SCALE:  wt_q  <= scale_exp_f(white_q, gain_q);
      WS_SQUARE: wt2_q <= T2_W'(wt_q) * T2_W'(wt_q);
      WS_TERMS: begin
        wnum_q <= curve_num_f(wt_q, wt2_q);
        wden_q <= curve_den_f(wt_q, wt2_q);
      end
      WS_NORM: begin
        wrem_q <= DEN_W'(wnum_q >> wsh);
        wdn_q  <= DEN_W'(wden_q >> wsh);
        wquo_q <= '0;
      end
      WS_FDIV: begin
        wrem_q <= wstep.rem;
        wquo_q <= wstep.quo;
        rrem_q <= '0;
        rquo_q <= '0;
      end
      WS_RDIV: begin
        rrem_q <= rrem_n;
        rquo_q <= rquo_n;
        if (cnt_q == '0) begin
          wcr_q <= wcr_n;
        end
      end
      default: ;
    endcase
  end

  //--------------------------------------------------------------------------
  // pixel pipeline
  //--------------------------------------------------------------------------
  assign acc = start && !busy;

  ftm_curve u_curve (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (acc),
    .pix_i   (pix_i),
    .gain_i  (gain_q),
    .valid_o (cv_vld),
    .f_o     (cv_f)
  );

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      nprod[c] = 52'(cv_f[c]) * 52'(wcr_q);
    end
    // d65 scale on x and z, y passes as is
    lprod[0] = 53'(n_q[0]) * 53'(D65_XF) + 53'(HALF20);
    lprod[1] = 53'(n_q[1]) << 20;
    lprod[2] = 53'(n_q[2]) * 53'(D65_ZF) + 53'(HALF20);
    // matrix row sums, negative clamps to zero, rounded to q20, clamped to 1.0
    for (int r = 0; r < NUM_CH; r++) begin
      rsum[r] = ACC_W'(mp_q[r][0]) + ACC_W'(mp_q[r][1]) + ACC_W'(mp_q[r][2]);
      rrnd[r] = (ACC_W'(rsum[r]) + HALF20) >> 20;
      if (rsum[r] <= 0) begin
        vlin[r] = '0;
      end else if (rrnd[r] > ACC_W'(Q20_ONE)) begin
        vlin[r] = Q20_ONE;
      end else begin
        vlin[r] = rrnd[r][V_W-1:0];
      end
    end
    // gamma code by binary search on the threshold table, msb first
    for (int s = 1; s <= CODE_W; s++) begin
      for (int c = 0; c < NUM_CH; c++) begin
        gcand[s][c] = gc_q[s-1][c] | (CODE_W'(1) << (CODE_W - s));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_vld_q <= 1'b0;
      l_vld_q <= 1'b0;
      m_vld_q <= 1'b0;
      g_vld_q <= '0;
    end else begin
      n_vld_q <= cv_vld;
      l_vld_q <= n_vld_q;
      m_vld_q <= l_vld_q;
      g_vld_q <= {g_vld_q[CODE_W-1:0], m_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NUM_CH; c++) begin
      n_q[c]   <= nprod[c][51:20];
      lin_q[c] <= lprod[c][52:20];
      for (int r = 0; r < NUM_CH; r++) begin
        mp_q[r][c] <= PROD_W'($signed({1'b0, lin_q[c]})) * PROD_W'(RGB_M[r][c]);
      end
      gv_q[0][c] <= vlin[c];
      gc_q[0][c] <= '0;
      for (int s = 1; s <= CODE_W; s++) begin
        gv_q[s][c] <= gv_q[s-1][c];
        if (gv_q[s-1][c] >= GAMMA_THR[gcand[s][c]]) begin
          gc_q[s][c] <= gcand[s][c];
        end else begin
          gc_q[s][c] <= gc_q[s-1][c];
        end
      end
    end
  end

  assign res_valid_o = g_vld_q[CODE_W];
  assign res_o.red   = gc_q[CODE_W][0];
  assign res_o.green = gc_q[CODE_W][1];
  assign res_o.blue  = gc_q[CODE_W][2];

  //--------------------------------------------------------------------------
  // checks
  //--------------------------------------------------------------------------
  `FTM_ASSERT_IMP(a_fixed_latency, clk_i, rst_ni, acc, ##PIPE_LAT res_valid_o, "result beat missing after fixed latency")
  `FTM_ASSERT_IMP(a_wcr_steady, clk_i, rst_ni, !busy && !$past(busy), $stable(wcr_q), "white reciprocal changed while not busy")
  `FTM_ASSERT_NXT(a_cfg_recompute, clk_i, rst_ni, cfg_we_i, busy, "register write did not start a recompute")

endmodule

// ===== bench/tb_filmic_tone_map_xyz_to_srgb.sv =====
// self-checking bench for the filmic tone mapper: random and directed xyz pixels
// depends on ftm_pkg and the filmic_tone_map_xyz_to_srgb rtl
`timescale 1ns / 100ps

module tb_filmic_tone_map_xyz_to_srgb;
  import ftm_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 50;   // a bit past the pipeline latency

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  pix_in_t               pix_i;
  logic                  res_valid_o;
  rgb_out_t              res_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  filmic_tone_map_xyz_to_srgb u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .pix_i       (pix_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // bench copy of the block's configuration and derived state
  longint unsigned gain_q16;
  longint unsigned white_q16;
  longint unsigned white_recip;
  longint unsigned srgb_thr [256];
  longint          xyz2rgb [3][3];
  longint unsigned d65_x_q20, d65_z_q20;

  pix_in_t  pixel_fifo [$];     // pixels waiting to be driven
  rgb_out_t rgb_expected [$];   // predicted colors in flight
  int       mismatch_cnt;
  int       pixels_sent;
  int       colors_seen;
  int       idle_cycles;
  int       gap_left;
  bit       no_gaps;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------- predictor ----------------

  function automatic longint unsigned q20_const(longint unsigned v7);
    return (v7 * 64'd1048576 + 64'd5000000) / 64'd10000000;
  endfunction

  function automatic longint unsigned pow5_trunc(longint unsigned r);
    longint unsigned a, b;
    a = (r * r) >> 20;
    b = (a * a) >> 20;
    return (b * r) >> 20;
  endfunction

  // gamma decision levels, linear below code 11, inverse power above
  task automatic build_srgb_levels();
    longint unsigned m, uq, u2, lo, hi, mid;
    srgb_thr[0] = 0;
    for (int k = 1; k < 256; k++) begin
      m = 64'(2 * k - 1);
      if (k <= 10) begin
        srgb_thr[k] = (m * 100 * 1048576 + 658919) / 658920;
      end else begin
        uq = ((m * 1000 + 28050) << 30) / 538050;
        u2 = (uq * uq) >> 40;
        lo = 0;
        hi = 64'd1 << 20;
        while (lo < hi) begin
          mid = (lo + hi + 1) / 2;
          if (pow5_trunc(mid) <= u2) lo = mid;
          else hi = mid - 1;
        end
        srgb_thr[k] = (u2 * lo) >> 20;
      end
    end
  endtask

  function automatic longint unsigned exposed(longint unsigned v);
    longint unsigned t;
    t = (v * gain_q16) >> 16;
    // very bright input saturates at 4096.0
    return (t > (64'd4096 << 16)) ? (64'd4096 << 16) : t;
  endfunction

  function automatic longint unsigned filmic_q20(longint unsigned t);
    longint unsigned num, den;
    num = t * (42 * t + 5 * 65536);
    den = 45 * t * t + 150 * t * 65536 + (64'd18 << 32);
    while (den >= (64'd1 << 43)) begin
      num = num >> 1;
      den = den >> 1;
    end
    return (num << 20) / den;
  endfunction

  task automatic update_white_recip();
    longint unsigned wf, r;
    wf = filmic_q20(exposed(white_q16));
    r = 64'hFFFF_FFFF;
    // zero curve at white saturates the reciprocal
    if (wf != 0) begin
      r = (64'd1 << 40) / wf;
      if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
    end
    white_recip = r;
  endtask

  function automatic logic [CODE_W-1:0] srgb_code(longint unsigned v);
    int code;
    code = 0;
    if (v > (64'd1 << 20)) v = 64'd1 << 20;   // brighter than white
    for (int k = 1; k < 256; k++)
      if (v >= srgb_thr[k]) code++;
    return CODE_W'(code);
  endfunction

  function automatic rgb_out_t tone_map_pixel(pix_in_t p);
    longint unsigned nrm [3];
    longint          lin [3];
    longint          acc;
    longint unsigned v;
    logic [CODE_W-1:0] code [3];
    rgb_out_t        o;
    nrm[0] = (filmic_q20(exposed(64'(p.cie_x))) * white_recip) >> 20;
    nrm[1] = (filmic_q20(exposed(64'(p.cie_y))) * white_recip) >> 20;
    nrm[2] = (filmic_q20(exposed(64'(p.cie_z))) * white_recip) >> 20;
    lin[0] = longint'((nrm[0] * d65_x_q20 + 64'd524288) >> 20);
    lin[1] = longint'(nrm[1]);
    lin[2] = longint'((nrm[2] * d65_z_q20 + 64'd524288) >> 20);
    for (int r = 0; r < 3; r++) begin
      acc = xyz2rgb[r][0] * lin[0] + xyz2rgb[r][1] * lin[1] + xyz2rgb[r][2] * lin[2];
      // out-of-gamut negatives clamp to black
      v = (acc <= 0) ? 64'd0 : (($unsigned(acc) + 64'd524288) >> 20);
      code[r] = srgb_code(v);
    end
    o.red   = code[0];
    o.green = code[1];
    o.blue  = code[2];
    return o;
  endfunction

  // ---------------- driver ----------------

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (no_gaps || sel < 60) return 0;
    if (sel < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 120);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start    <= 1'b0;
      pix_i    <= '0;
      gap_left <= 0;
    end else begin
      // beat taken at this edge: predict now, config cannot change mid-phase
      if (start && !busy) begin
        rgb_expected.push_back(tone_map_pixel(pix_i));
        pixels_sent++;
      end
      if (start && busy) begin
        // hold the pixel until busy drops
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start    <= 1'b0;
      end else if (pixel_fifo.size() > 0) begin
        pix_i    <= pixel_fifo.pop_front();
        start    <= 1'b1;
        gap_left <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  always @(posedge clk_i) begin
    rgb_out_t want;
    if (rst_ni && res_valid_o) begin
      colors_seen++;
      if (rgb_expected.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        want = rgb_expected.pop_front();
        if (res_o.red !== want.red)     report_mismatch("red", res_o.red, want.red);
        if (res_o.green !== want.green) report_mismatch("green", res_o.green, want.green);
        if (res_o.blue !== want.blue)   report_mismatch("blue", res_o.blue, want.blue);
      end
    end
  end

  // watchdog: no beat moving in either direction for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d colors outstanding", rgb_expected.size());
      $display("filmic_tone_map_xyz_to_srgb verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------- sequencing ----------------

  task automatic write_reg(cfg_reg_e idx, longint unsigned value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_EXPOSURE_GAIN) gain_q16 = value & 64'hFF_FFFF;
    else white_q16 = value & 64'hFFFF_FFFF;
    update_white_recip();
    // recompute kicks in: wait for busy to show before feeding pixels
    do @(posedge clk_i); while (!busy);
  endtask

  // all pixels taken, all colors back, pipeline empty
  task automatic drain();
    while (pixel_fifo.size() > 0 || start) @(posedge clk_i);
    while (rgb_expected.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [IN_W-1:0] rand_channel(longint unsigned wl);
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom >> $urandom_range(4, 31);
      2: return $urandom_range(0, 262144);
      3: return IN_W'((wl * $urandom_range(0, 200)) / 100);
      default: return $urandom >> $urandom_range(12, 20);
    endcase
  endfunction

  task automatic queue_random(int n);
    pix_in_t p;
    for (int i = 0; i < n; i++) begin
      p.cie_x = rand_channel(white_q16);
      p.cie_y = rand_channel(white_q16);
      p.cie_z = rand_channel(white_q16);
      pixel_fifo.push_back(p);
    end
  endtask

  task automatic queue_directed();
    pixel_fifo.push_back('{32'd0, 32'd0, 32'd0});
    pixel_fifo.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    pixel_fifo.push_back('{32'hFFFF_FFFF, 32'd0, 32'd0});     // red-ish, out of gamut
    pixel_fifo.push_back('{32'd0, 32'hFFFF_FFFF, 32'd0});
    pixel_fifo.push_back('{32'd0, 32'd0, 32'hFFFF_FFFF});     // blue-ish, out of gamut
    pixel_fifo.push_back('{32'd62290, 32'd65536, 32'd108906}); // x and y of d65 white at 1.0, z above it
    pixel_fifo.push_back('{32'd1, 32'd1, 32'd1});
    pixel_fifo.push_back('{32'd16, 32'd20, 32'd22});          // linear gamma segment
    pixel_fifo.push_back('{32'd200, 32'd210, 32'd230});
    pixel_fifo.push_back('{32'h1000_0000, 32'h1000_0000, 32'h1000_0000}); // cap region
    pixel_fifo.push_back('{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA});
    pixel_fifo.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555});
    pixel_fifo.push_back('{32'd131072, 32'd131072, 32'd131072}); // above white
    pixel_fifo.push_back('{32'd32768, 32'd32768, 32'd32768});
    pixel_fifo.push_back('{32'd65535, 32'd0, 32'd65535});
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_EXPOSURE_GAIN;
    cfg_data_i   = '0;
    mismatch_cnt = 0;
    pixels_sent  = 0;
    colors_seen  = 0;
    idle_cycles  = 0;
    no_gaps      = 1'b0;

    d65_x_q20 = (64'd31271 * 64'd1048576 + 64'd16451) / 64'd32902;
    d65_z_q20 = (64'd35827 * 64'd1048576 + 64'd16451) / 64'd32902;
    xyz2rgb[0][0] =  longint'(q20_const(32404542));
    xyz2rgb[0][1] = -longint'(q20_const(15371385));
    xyz2rgb[0][2] = -longint'(q20_const(4985314));
    xyz2rgb[1][0] = -longint'(q20_const(9692660));
    xyz2rgb[1][1] =  longint'(q20_const(18760108));
    xyz2rgb[1][2] =  longint'(q20_const(415560));
    xyz2rgb[2][0] =  longint'(q20_const(556434));
    xyz2rgb[2][1] = -longint'(q20_const(2040259));
    xyz2rgb[2][2] =  longint'(q20_const(10572252));
    build_srgb_levels();
    gain_q16  = 64'd65536;
    white_q16 = 64'd65536;
    update_white_recip();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: directed set, then a back-to-back random burst
    queue_directed();
    no_gaps = 1'b1;
    queue_random(60);
    drain();
    no_gaps = 1'b0;

    // brighter white, unit gain
    write_reg(REG_WHITE_LEVEL, 64'd4 << 16);
    queue_directed();
    queue_random(110);
    drain();

    // gain at maximum, smallest nonzero white
    write_reg(REG_EXPOSURE_GAIN, 64'hFF_FFFF);
    write_reg(REG_WHITE_LEVEL, 64'd1);
    queue_random(110);
    drain();

    // zero gain: curve at white is zero, every pixel black
    write_reg(REG_EXPOSURE_GAIN, 64'd0);
    write_reg(REG_WHITE_LEVEL, 64'h100);
    queue_random(60);
    drain();

    // tiny gain, largest white
    write_reg(REG_EXPOSURE_GAIN, 64'd1);
    write_reg(REG_WHITE_LEVEL, 64'hFFFF_FFFF);
    queue_random(90);
    drain();

    // a few random settings
    for (int s = 0; s < 3; s++) begin
      write_reg(REG_EXPOSURE_GAIN, $urandom_range(0, 24'hFF_FFFF) >> $urandom_range(0, 10));
      write_reg(REG_WHITE_LEVEL, ($urandom >> $urandom_range(0, 16)) | 1);
      no_gaps = (s == 1);
      queue_random(100);
      drain();
    end

    $display("covered %0d pixels and %0d colors over eight exposure/white settings",
             pixels_sent, colors_seen);
    $display("settings included gain extremes, zero curve at white and saturated pixels");
    if (mismatch_cnt == 0 && rgb_expected.size() == 0) begin
      $display("filmic_tone_map_xyz_to_srgb verification clean");
    end else begin
      $display("%0d mismatches, %0d colors never seen", mismatch_cnt, rgb_expected.size());
      $display("filmic_tone_map_xyz_to_srgb verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/ftm_pkg.sv
design/ftm_curve.sv
design/filmic_tone_map_xyz_to_srgb.sv
bench/tb_filmic_tone_map_xyz_to_srgb.sv
